[hdl/vld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vld_pkg
// Shared constants, types and the filter tap table of the vibration level
// detector.
// ----------------------------------------------------------------------------
package vld_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int TAP_COUNT     = 53;
   localparam int WINDOW_LENGTH = 40;

   // filter
   localparam int COEF_W     = 16;
   localparam int COEF_FRAC  = 15;
   localparam int PROD_W     = COEF_W + SAMPLE_WIDTH;
   localparam int ACC_W      = 40;
   localparam int HIST_DEPTH = (TAP_COUNT > 1) ? TAP_COUNT - 1 : 1;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int HIST_PW    = HIST_AW + 2;
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
   localparam int TAP_CW     = $clog2(TAP_COUNT + 1);

   // sliding window and mean
   localparam int WIN_AW      = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int SUM_W       = 22;
   localparam int DIV_SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
   localparam int DIV_RECIP_W = SUM_W + 2;
   localparam longint DIV_RECIP_L =
      ((64'sd1 <<< DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(DIV_RECIP_L);
   localparam int DIV_PW = SUM_W + DIV_RECIP_W;
   localparam logic [SAMPLE_WIDTH-1:0] MEAN_MAX = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int THRESH_W = 16;
   localparam logic [CSR_AW-3:0]   REG_LEVEL_THRESHOLD = '0;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET     = 16'd1066;

   typedef struct packed {
      logic                           valid;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } vld_queue_type;

   function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_CW-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         0:  c = 16'sd0;
         1:  c = -16'sd12;
         2:  c = -16'sd27;
         3:  c = -16'sd44;
         4:  c = -16'sd62;
         5:  c = -16'sd78;
         6:  c = -16'sd84;
         7:  c = -16'sd73;
         8:  c = -16'sd39;
         9:  c = 16'sd24;
         10: c = 16'sd114;
         11: c = 16'sd224;
         12: c = 16'sd337;
         13: c = 16'sd433;
         14: c = 16'sd484;
         15: c = 16'sd461;
         16: c = 16'sd341;
         17: c = 16'sd105;
         18: c = -16'sd250;
         19: c = -16'sd715;
         20: c = -16'sd1265;
         21: c = -16'sd1860;
         22: c = -16'sd2452;
         23: c = -16'sd2986;
         24: c = -16'sd3411;
         25: c = -16'sd3686;
         26: c = 16'sd28982;
         27: c = -16'sd3686;
         28: c = -16'sd3411;
         29: c = -16'sd2986;
         30: c = -16'sd2452;
         31: c = -16'sd1860;
         32: c = -16'sd1265;
         33: c = -16'sd715;
         34: c = -16'sd250;
         35: c = 16'sd105;
         36: c = 16'sd341;
         37: c = 16'sd461;
         38: c = 16'sd484;
         39: c = 16'sd433;
         40: c = 16'sd337;
         41: c = 16'sd224;
         42: c = 16'sd114;
         43: c = 16'sd24;
         44: c = -16'sd39;
         45: c = -16'sd73;
         46: c = -16'sd84;
         47: c = -16'sd78;
         48: c = -16'sd62;
         49: c = -16'sd44;
         50: c = -16'sd27;
         51: c = -16'sd12;
         52: c = 16'sd0;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

endpackage

[hdl/vld_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vld_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/vld_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vld_front
// Accepts samples, picks the largest axis and queues it for the filter.
// ----------------------------------------------------------------------------
module vld_front import vld_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
   input  logic                           pop,
   output vld_queue_type                  queue
);

   logic signed [SAMPLE_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]            count_ff, count_in;
   logic signed [SAMPLE_WIDTH-1:0] axis_max;
   logic                           push;
   logic                           take;

   always_comb begin
      axis_max = accel_x;
      if (accel_y > axis_max) begin
         axis_max = accel_y;
      end
      if (accel_z > axis_max) begin
         axis_max = accel_z;
      end
   end

   assign in_stall     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign push         = in_valid && !in_stall;
   assign take         = pop && (count_ff != '0);
   assign queue.valid  = (count_ff != '0);
   assign queue.sample = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= axis_max;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/vld_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vld_back
// Shared multiply-accumulate over the filter taps, rounding and saturation,
// sliding magnitude window, mean and alarm, with the result register.
// ----------------------------------------------------------------------------
module vld_back import vld_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  vld_queue_type                  queue,
   output logic                           pop,
   input  logic [THRESH_W-1:0]            threshold,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
   output logic [SAMPLE_WIDTH-1:0]        window_mean,
   output logic                           alarm
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROUND,
      ST_SAT,
      ST_WINDOW,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic [ACC_W-1:0] SAT_POS    = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic [ACC_W-1:0] SAT_NEG    = ACC_W'(1 << (SAMPLE_WIDTH - 1));

   state_type                      state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [TAP_CW-1:0]              issue_k_ff, issue_k_in;
   logic                           s1_vld_ff, s1_vld_in;
   logic [TAP_CW-1:0]              s1_k_ff, s1_k_in;
   logic                           s1_cur_ff, s1_cur_in;
   logic                           s1_ok_ff, s1_ok_in;
   logic                           s2_vld_ff, s2_vld_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_W-1:0]               abs_ff, abs_in;
   logic                           neg_ff, neg_in;
   logic signed [SAMPLE_WIDTH-1:0] filt_ff, filt_in;
   logic [SAMPLE_WIDTH-1:0]        mag_ff, mag_in;
   logic [HIST_AW-1:0]             hist_wp_ff, hist_wp_in;
   logic [HIST_CW-1:0]             hist_cnt_ff, hist_cnt_in;
   logic [WIN_AW-1:0]              win_pos_ff, win_pos_in;
   logic                           win_full_ff, win_full_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [DIV_PW-1:0]              div_prod_ff, div_prod_in;
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] out_filt_ff, out_filt_in;
   logic [SAMPLE_WIDTH-1:0]        out_mean_ff, out_mean_in;
   logic                           out_alarm_ff, out_alarm_in;

   logic [HIST_PW-1:0]             hist_raw;
   logic [HIST_AW-1:0]             hist_rd_addr;
   logic [SAMPLE_WIDTH-1:0]        hist_rd_data;
   logic                           hist_wr_en;
   logic [SAMPLE_WIDTH-1:0]        win_rd_data;
   logic                           win_wr_en;
   logic signed [SAMPLE_WIDTH-1:0] operand;
   logic [ACC_W-1:0]               rounded;
   logic [SAMPLE_WIDTH-1:0]        old_mag;
   logic [DIV_PW-1:0]              mean_full;
   logic [SAMPLE_WIDTH-1:0]        mean;
   logic                           out_free;

   // history ring, read newest first: age k sits k slots behind the write pointer
   always_comb begin
      hist_raw = HIST_PW'(hist_wp_ff) + HIST_PW'(HIST_DEPTH) - HIST_PW'(issue_k_ff);
      if (hist_raw >= HIST_PW'(HIST_DEPTH)) begin
         hist_raw = hist_raw - HIST_PW'(HIST_DEPTH);
      end
      hist_rd_addr = hist_raw[HIST_AW-1:0];
   end

   assign hist_wr_en = (state_ff == ST_ROUND);
   assign win_wr_en  = (state_ff == ST_WINDOW);

   vld_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wp_ff),
      .wr_data (sample_ff),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   vld_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_LENGTH)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (win_pos_ff),
      .wr_data (mag_ff),
      .rd_addr (win_pos_ff),
      .rd_data (win_rd_data)
   );

   assign pop      = (state_ff == ST_IDLE) && queue.valid;
   assign out_free = !out_valid_ff || !out_stall;
   assign operand  = s1_cur_ff ? sample_ff :
                     (s1_ok_ff ? $signed(hist_rd_data) : '0);
   assign rounded  = (abs_ff + ROUND_HALF) >> COEF_FRAC;
   assign old_mag  = win_full_ff ? win_rd_data : '0;
   assign mean_full = div_prod_ff >> DIV_SHIFT;
   assign mean     = mean_full[SAMPLE_WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      issue_k_in   = issue_k_ff;
      s1_vld_in    = 1'b0;
      s1_k_in      = issue_k_ff;
      s1_cur_in    = (issue_k_ff == '0);
      s1_ok_in     = (issue_k_ff != '0) && (issue_k_ff <= TAP_CW'(hist_cnt_ff));
      s2_vld_in    = s1_vld_ff;
      prod_in      = PROD_W'(tap_coef(s1_k_ff)) * PROD_W'(operand);
      acc_in       = acc_ff;
      abs_in       = abs_ff;
      neg_in       = neg_ff;
      filt_in      = filt_ff;
      mag_in       = mag_ff;
      hist_wp_in   = hist_wp_ff;
      hist_cnt_in  = hist_cnt_ff;
      win_pos_in   = win_pos_ff;
      win_full_in  = win_full_ff;
      sum_in       = sum_ff;
      div_prod_in  = DIV_PW'(sum_ff) * DIV_PW'(DIV_RECIP);
      out_valid_in = out_valid_ff && out_stall;
      out_filt_in  = out_filt_ff;
      out_mean_in  = out_mean_ff;
      out_alarm_in = out_alarm_ff;

      if (s2_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (queue.valid) begin
               sample_in  = queue.sample;
               issue_k_in = '0;
               acc_in     = '0;
               state_in   = ST_MAC;
            end
         end
         ST_MAC: begin
            if (issue_k_ff < TAP_CW'(TAP_COUNT)) begin
               s1_vld_in  = 1'b1;
               issue_k_in = issue_k_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            neg_in = acc_ff[ACC_W-1];
            abs_in = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            if (TAP_COUNT > 1) begin
               hist_wp_in = (hist_wp_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0 :
                            hist_wp_ff + 1'b1;
               if (hist_cnt_ff != HIST_CW'(HIST_DEPTH)) begin
                  hist_cnt_in = hist_cnt_ff + 1'b1;
               end
            end
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (neg_ff) begin
               if (rounded >= SAT_NEG) begin
                  filt_in = $signed(SAT_NEG[SAMPLE_WIDTH-1:0]);
                  mag_in  = SAT_NEG[SAMPLE_WIDTH-1:0];
               end else begin
                  filt_in = -$signed(rounded[SAMPLE_WIDTH-1:0]);
                  mag_in  = rounded[SAMPLE_WIDTH-1:0];
               end
            end else begin
               if (rounded > SAT_POS) begin
                  filt_in = $signed(SAT_POS[SAMPLE_WIDTH-1:0]);
                  mag_in  = SAT_POS[SAMPLE_WIDTH-1:0];
               end else begin
                  filt_in = $signed(rounded[SAMPLE_WIDTH-1:0]);
                  mag_in  = rounded[SAMPLE_WIDTH-1:0];
               end
            end
            state_in = ST_WINDOW;
         end
         ST_WINDOW: begin
            sum_in = sum_ff - SUM_W'(old_mag) + SUM_W'(mag_ff);
            if (win_pos_ff == WIN_AW'(WINDOW_LENGTH - 1)) begin
               win_pos_in  = '0;
               win_full_in = 1'b1;
            end else begin
               win_pos_in = win_pos_ff + 1'b1;
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_filt_in  = filt_ff;
               out_mean_in  = mean;
               out_alarm_in = (THRESH_W'(mean) >= threshold);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      s1_k_ff      <= s1_k_in;
      s1_cur_ff    <= s1_cur_in;
      s1_ok_ff     <= s1_ok_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      abs_ff       <= abs_in;
      neg_ff       <= neg_in;
      filt_ff      <= filt_in;
      mag_ff       <= mag_in;
      div_prod_ff  <= div_prod_in;
      out_filt_ff  <= out_filt_in;
      out_mean_ff  <= out_mean_in;
      out_alarm_ff <= out_alarm_in;
      issue_k_ff   <= issue_k_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         hist_wp_ff   <= '0;
         hist_cnt_ff  <= '0;
         win_pos_ff   <= '0;
         win_full_ff  <= 1'b0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         hist_wp_ff   <= hist_wp_in;
         hist_cnt_ff  <= hist_cnt_in;
         win_pos_ff   <= win_pos_in;
         win_full_ff  <= win_full_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid       = out_valid_ff;
   assign filtered_sample = out_filt_ff;
   assign window_mean     = out_mean_ff;
   assign alarm           = out_alarm_ff;

endmodule

[hdl/vibration_level_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration_level_detector_unit
// Three-axis vibration level detector: axis maximum, 53-tap FIR, sliding
// 40-sample magnitude mean and threshold alarm.
// ----------------------------------------------------------------------------
// The filter takes a new sample only once the previous result has been
// handed to the output register: one multiply-accumulate unit walks all 53
// filter taps at one tap per cycle through the history RAM, followed by
// pipeline drain, rounding, saturation, window update, mean and output
// steps. Samples are queued two deep in front of the filter, so the
// input stalls only while the queue is full; the filter and window state start
// at zero after reset with no clearing pass. The alarm threshold lives at byte
// address 0 of the register port and resets to 1066 counts.
module vibration_level_detector_unit import vld_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   output logic [SAMPLE_WIDTH-1:0]        rsp_window_mean,
   output logic                           rsp_alarm,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [CSR_AW-1:0]              paddr,
   input  logic [CSR_DW-1:0]              pwdata,
   output logic [CSR_DW-1:0]              prdata,
   output logic                           pready
);

   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic                reg_hit;
   vld_queue_type       queue;
   logic                pop;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_AW-1:2] == REG_LEVEL_THRESHOLD);
   assign prdata  = reg_hit ? CSR_DW'(threshold_ff) : '0;

   always_comb begin
      threshold_in = threshold_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         threshold_in = pwdata[THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   vld_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .accel_x  (req_accel_x),
      .accel_y  (req_accel_y),
      .accel_z  (req_accel_z),
      .pop      (pop),
      .queue    (queue)
   );

   vld_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue           (queue),
      .pop             (pop),
      .threshold       (threshold_ff),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .filtered_sample (rsp_filtered_sample),
      .window_mean     (rsp_window_mean),
      .alarm           (rsp_alarm)
   );

endmodule

[hdl/vld_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vld_checker
// Port-level checks of the vibration level detector, bound to the top level.
// ----------------------------------------------------------------------------
module vld_checker import vld_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   input logic [SAMPLE_WIDTH-1:0]        rsp_window_mean,
   input logic                           rsp_alarm
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_sample) &&
         $stable(rsp_window_mean) && $stable(rsp_alarm))
      else $error("stalled result changed");

   // mean of magnitudes never exceeds the largest magnitude
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_mean <= MEAN_MAX)
      else $error("window mean out of range");

   // reset leaves no result pending and the queue open
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state after reset");

endmodule

bind vibration_level_detector_unit vld_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_filtered_sample (rsp_filtered_sample),
   .rsp_window_mean     (rsp_window_mean),
   .rsp_alarm           (rsp_alarm)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vibration level detector. Three-axis samples
// are driven through the request channel while a scoreboard class keeps its
// own filter history, magnitude window and threshold. Every response is
// checked field by field, and register readback is checked after each write.
// Directed corner samples come first, then shaped random waveforms run under
// several thresholds, with random bursts of idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb import vld_pkg::*;;

   localparam int CLOCK_HALF       = 10;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_SAMPLES    = 165;
   localparam int PHASE_COUNT      = 6;
   localparam int SETTLE_CYCLES    = 100;
   localparam int REPORT_LIMIT     = 10;
   localparam int SAMPLE_MAX       = 2 ** (SAMPLE_WIDTH - 1) - 1;
   localparam int SAMPLE_MIN       = -SAMPLE_MAX - 1;
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = SAMPLE_WIDTH'(SAMPLE_MAX);
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = SAMPLE_WIDTH'(SAMPLE_MIN);
   localparam logic [CSR_AW-3:0] REG_UNUSED = 1'b1;

   typedef enum int {
      WAVE_UNIFORM,
      WAVE_NOISE,
      WAVE_NYQUIST,
      WAVE_MATCHED,
      WAVE_SQUARE
   } wave_kind_type;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic [SAMPLE_WIDTH-1:0]        mean;
      logic                           alarm;
   } level_result_type;

   class level_scoreboard;
      int                  tap_weight[TAP_COUNT];
      int                  peak_history[HIST_DEPTH];
      int unsigned         mag_history[WINDOW_LENGTH];
      int unsigned         mag_sum;
      int unsigned         slot;
      logic [THRESH_W-1:0] threshold;
      level_result_type    expected_levels[$];
      int                  mismatch_count;

      function new();
         tap_weight = '{
            0, -12, -27, -44, -62, -78, -84, -73, -39, 24, 114, 224, 337, 433,
            484, 461, 341, 105, -250, -715, -1265, -1860, -2452, -2986, -3411,
            -3686, 28982, -3686, -3411, -2986, -2452, -1860, -1265, -715, -250,
            105, 341, 461, 484, 433, 337, 224, 114, 24, -39, -73, -84, -78, -62,
            -44, -27, -12, 0};
         foreach (peak_history[i]) peak_history[i] = 0;
         foreach (mag_history[i]) mag_history[i] = 0;
         mag_sum        = 0;
         slot           = 0;
         threshold      = THRESHOLD_RESET;
         mismatch_count = 0;
      endfunction

      function void write_register(input logic [CSR_AW-3:0] index,
                                   input logic [CSR_DW-1:0] value);
         if (index == REG_LEVEL_THRESHOLD) begin
            threshold = value[THRESH_W-1:0];
         end
      endfunction

      function void note_sample(input logic signed [SAMPLE_WIDTH-1:0] ax,
                                input logic signed [SAMPLE_WIDTH-1:0] ay,
                                input logic signed [SAMPLE_WIDTH-1:0] az);
         int               peak;
         int               k;
         longint           acc;
         longint           q;
         int unsigned      magnitude;
         int unsigned      mean;
         level_result_type r;
         peak = ax;
         if (ay > peak) peak = ay;
         if (az > peak) peak = az;
         acc = longint'(tap_weight[0]) * peak;
         for (k = 1; k < TAP_COUNT; k++) begin
            acc += longint'(tap_weight[k]) * peak_history[k-1];
         end
         for (k = TAP_COUNT - 2; k > 0; k--) begin
            peak_history[k] = peak_history[k-1];
         end
         peak_history[0] = peak;
         // divide by 2^15 rounding half away from zero
         if (acc >= 0) begin
            q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) / (longint'(1) <<< COEF_FRAC);
         end else begin
            q = -((-acc + (longint'(1) <<< (COEF_FRAC - 1))) / (longint'(1) <<< COEF_FRAC));
         end
         if (q > SAMPLE_MAX) q = SAMPLE_MAX;
         if (q < SAMPLE_MIN) q = SAMPLE_MIN;
         magnitude = (q < 0) ? int'(-q) : int'(q);
         mag_sum = mag_sum - mag_history[slot] + magnitude;
         mag_history[slot] = magnitude;
         slot = (slot + 1 == WINDOW_LENGTH) ? 0 : slot + 1;
         mean = mag_sum / WINDOW_LENGTH;
         r.filtered = SAMPLE_WIDTH'(q);
         r.mean     = SAMPLE_WIDTH'(mean);
         r.alarm    = (mean >= threshold);
         expected_levels.push_back(r);
      endfunction

      function void check_result(input logic signed [SAMPLE_WIDTH-1:0] f,
                                 input logic [SAMPLE_WIDTH-1:0] m,
                                 input logic a);
         level_result_type want;
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected transfer: f=%0d mean=%0d alarm=%0b", f, m, a);
            end
            return;
         end
         want = expected_levels.pop_front();
         if (f !== want.filtered || m !== want.mean || a !== want.alarm) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display({"level mismatch: expected f=%0d mean=%0d alarm=%0b, ",
                         "got f=%0d mean=%0d alarm=%0b"},
                        want.filtered, want.mean, want.alarm, f, m, a);
            end
         end
      endfunction

      function void check_readback(input logic [CSR_DW-1:0] got);
         if (got !== CSR_DW'(threshold)) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("threshold readback: expected %0d, got %0d", threshold, got);
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_accel_x = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_accel_y = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_accel_z = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_sample;
   logic [SAMPLE_WIDTH-1:0]        rsp_window_mean;
   logic                           rsp_alarm;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [CSR_AW-1:0]              paddr = '0;
   logic [CSR_DW-1:0]              pwdata = '0;
   logic [CSR_DW-1:0]              prdata;
   logic                           pready;

   level_scoreboard levels = new();

   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   bit hold_request       = 1'b0;
   int quiet_cycles       = 0;

   vibration_level_detector_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_window_mean     (rsp_window_mean),
      .rsp_alarm           (rsp_alarm),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            levels.note_sample(req_accel_x, req_accel_y, req_accel_z);
         end
         if (rsp_valid && !rsp_stall) begin
            levels.check_result(rsp_filtered_sample, rsp_window_mean, rsp_alarm);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // response side stall bursts and the long hold
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_stall_pct != 0 &&
                      $urandom_range(0, 99) < receiver_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] ax,
                              input logic signed [SAMPLE_WIDTH-1:0] ay,
                              input logic signed [SAMPLE_WIDTH-1:0] az);
      if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one axis carries the wanted maximum, the others sit at or below it
   task automatic send_peak(input int level);
      int axis_val[3];
      int holder;
      int i;
      if (level > SAMPLE_MAX) level = SAMPLE_MAX;
      if (level < SAMPLE_MIN) level = SAMPLE_MIN;
      holder = $urandom_range(0, 2);
      for (i = 0; i < 3; i++) begin
         if (i == holder || $urandom_range(0, 15) == 0) begin
            axis_val[i] = level;
         end else begin
            axis_val[i] = int'($urandom_range(0, level - SAMPLE_MIN)) + SAMPLE_MIN;
         end
      end
      send_sample(SAMPLE_WIDTH'(axis_val[0]), SAMPLE_WIDTH'(axis_val[1]),
                  SAMPLE_WIDTH'(axis_val[2]));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (levels.expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-3:0] index, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      levels.write_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_check();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {REG_LEVEL_THRESHOLD, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      levels.check_readback(prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_random(input int count);
      wave_kind_type kind;
      int            sent;
      int            seg_left;
      int            period;
      int            step;
      int            amp;
      int            spread;
      sent     = 0;
      seg_left = 0;
      kind     = WAVE_UNIFORM;
      period   = 2;
      step     = 0;
      amp      = 0;
      spread   = 1;
      while (sent < count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 80);
            kind     = wave_kind_type'($urandom_range(0, 4));
            period   = $urandom_range(2, 24);
            spread   = $urandom_range(1, 3000);
            step     = 0;
            case ($urandom_range(0, 3))
               0:       amp = SAMPLE_MAX;
               1:       amp = SAMPLE_MIN;
               default: amp = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
            endcase
         end
         case (kind)
            WAVE_UNIFORM: begin
               send_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom),
                           SAMPLE_WIDTH'($urandom));
            end
            WAVE_NOISE: begin
               send_peak(int'($urandom_range(0, 2 * spread)) - spread);
            end
            WAVE_NYQUIST: begin
               send_peak((step % 2 == 0) ? amp : -amp);
            end
            WAVE_MATCHED: begin
               send_peak((levels.tap_weight[step % TAP_COUNT] < 0) ? -amp : amp);
            end
            default: begin
               send_peak((step % period < period / 2) ? amp : -amp);
            end
         endcase
         step++;
         seg_left--;
         sent++;
      end
   endtask

   initial begin
      int i;
      int ph;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_read_check();

      // directed corners at the reset threshold
      send_sample('0, '0, '0);
      send_sample(S_MAX, S_MAX, S_MAX);
      send_sample(S_MIN, S_MIN, S_MIN);
      send_sample(S_MAX, S_MIN, '0);
      send_sample(S_MIN, S_MAX, -16'sd1);
      send_sample(-16'sd1, -16'sd2, 16'sd12345);
      send_sample(-16'sd5, -16'sd5, -16'sd9);
      send_sample(16'sd100, -16'sd3, 16'sd100);
      send_sample(-16'sd7, 16'sd7, 16'sd7);
      send_sample(16'sh5555, 16'sh2AAA, 16'sh00FF);
      send_sample(16'shAAAA, 16'shD555, 16'shFF00);
      for (i = 0; i < 10; i++) begin
         send_sample(i[0] ? S_MIN : S_MAX, i[0] ? S_MIN : S_MAX, i[0] ? S_MIN : S_MAX);
      end
      send_sample('0, '0, '0);

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               csr_write(REG_LEVEL_THRESHOLD, '0);
               sender_gap_pct     = 20;
               receiver_stall_pct = 15;
            end
            1: begin
               csr_write(REG_LEVEL_THRESHOLD, 32'h0001_8000);
               sender_gap_pct     = 10;
               receiver_stall_pct = 10;
               hold_request       = 1'b1;
            end
            2: begin
               csr_write(REG_UNUSED, '1);
               csr_read_check();
               csr_write(REG_LEVEL_THRESHOLD, 32'hFFFF_0000 | $urandom_range(0, 32768));
               sender_gap_pct     = 0;
               receiver_stall_pct = 0;
            end
            3: begin
               csr_write(REG_LEVEL_THRESHOLD, 32'd200);
               sender_gap_pct     = 50;
               receiver_stall_pct = 40;
            end
            4: begin
               csr_write(REG_LEVEL_THRESHOLD, CSR_DW'($urandom_range(500, 8000)));
               sender_gap_pct     = 25;
               receiver_stall_pct = 5;
            end
            default: begin
               csr_write(REG_LEVEL_THRESHOLD, CSR_DW'(THRESHOLD_RESET));
               sender_gap_pct     = 0;
               receiver_stall_pct = 0;
            end
         endcase
         csr_read_check();
         run_random(PHASE_SAMPLES);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (levels.expected_levels.size() != 0) begin
         levels.mismatch_count++;
      end
      if (levels.mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/vld_pkg.sv
hdl/vld_ram.sv
hdl/vld_front.sv
hdl/vld_back.sv
hdl/vibration_level_detector_unit.sv
hdl/vld_checker.sv
test/tb.sv
